/* rtl/quantized_mlp_4x8_infer_macros.svh */
// Assertion macros for the top-level RTL.
`ifndef QUANTIZED_MLP_4X8_INFER_MACROS_SVH
`define QUANTIZED_MLP_4X8_INFER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define QMLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define QMLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qmlp_pkg.sv */
package qmlp_pkg;

    // Network shape and weight word layout
    localparam int INPUT_COUNT  = 4;
    localparam int HIDDEN_COUNT = 8;
    localparam int HID_B_BASE   = INPUT_COUNT * HIDDEN_COUNT;
    localparam int OUT_W_BASE   = HID_B_BASE + HIDDEN_COUNT;
    localparam int OUT_B_INDEX  = OUT_W_BASE + HIDDEN_COUNT;

    // Field widths
    localparam int WORD_W    = 16;
    localparam int ACC_W     = 32;
    localparam int HID_W     = 15;
    localparam int SHIFT_W   = 4;
    localparam int INDEX_W   = 6;
    localparam int CFG_IDX_W = 2;

    // Derived index and counter widths
    localparam int IN_IDX_W  = $clog2(INPUT_COUNT);
    localparam int HID_IDX_W = $clog2(HIDDEN_COUNT);
    localparam int LSTEP_W   = $clog2(INPUT_COUNT + 1);
    localparam int MSTEP_W   = $clog2(HIDDEN_COUNT + 1);

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_INFER = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_Q_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MAX = 2'd2;

    typedef logic signed [WORD_W-1:0]           t_word;
    typedef logic signed [ACC_W-1:0]            t_acc;
    typedef logic [HID_W-1:0]                   t_hidden;
    typedef logic [HIDDEN_COUNT-1:0][HID_W-1:0] t_hidden_vec;
    typedef logic [SHIFT_W-1:0]                 t_shift;
    typedef logic [INDEX_W-1:0]                 t_index;
    typedef logic [CFG_IDX_W-1:0]               t_cfg_idx;
    typedef logic [ACC_W-1:0]                   t_cfg_data;
    typedef logic [IN_IDX_W-1:0]                t_in_sel;
    typedef logic [HID_IDX_W-1:0]               t_hid_sel;

    // Reset values of the configuration registers
    localparam t_shift Q_SHIFT_RESET   = 4'd8;
    localparam t_acc   RATIO_MIN_RESET = 32'sh0000_0000;
    localparam t_acc   RATIO_MAX_RESET = 32'sh7fff_ffff;
    localparam t_acc   HIDDEN_LIMIT    = 32'sh0000_7fff;

    // Lane sequencing controls
    typedef struct packed {
        logic preload;
        logic mac;
        logic fin;
    } t_lane_ctl;

    // Weight write into one lane
    typedef struct packed {
        logic    w_en;
        t_in_sel w_sel;
        logic    b_en;
        t_word   data;
    } t_lane_wr;

    // Weight write into the merge stage
    typedef struct packed {
        logic     ow_en;
        t_hid_sel ow_sel;
        logic     ob_en;
        t_word    data;
    } t_merge_wr;

    // Merge stage status toward the controller
    typedef struct packed {
        logic busy;
        logic can_start;
    } t_merge_stat;

    // Sign-extend a bias word and scale it up by the fraction bits
    function automatic t_acc bias_scale(input t_word bias, input t_shift q);
        t_acc ext;
        ext = t_acc'(bias);
        return ext << q;
    endfunction

    // Arithmetic shift down by the fraction bits
    function automatic t_acc shift_down(input t_acc v, input t_shift q);
        return v >>> q;
    endfunction

    // Clamp a hidden activation to 0..32767
    function automatic t_hidden hidden_clamp(input t_acc v);
        t_hidden res;
        if (v < 0) begin
            res = '0;
        end else if (v > HIDDEN_LIMIT) begin
            res = HIDDEN_LIMIT[HID_W-1:0];
        end else begin
            res = v[HID_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/qmlp_lane.sv */
module qmlp_lane (
    input  logic                i_clk,
    input  qmlp_pkg::t_lane_wr  i_wr,
    input  qmlp_pkg::t_lane_ctl i_ctl,
    input  qmlp_pkg::t_in_sel   i_sel,
    input  qmlp_pkg::t_word     i_feat,
    input  qmlp_pkg::t_shift    i_q_shift,
    output qmlp_pkg::t_hidden   o_hidden
);
    import qmlp_pkg::*;

    t_word   r_w [INPUT_COUNT];
    t_word   r_bias;
    t_acc    r_acc;
    t_acc    n_acc;
    t_hidden r_hidden;
    t_acc    w_prod;

    // Hold this unit's weight row and bias
    always_ff @(posedge i_clk) begin
        if (i_wr.w_en) begin
            r_w[i_wr.w_sel] <= i_wr.data;
        end
        if (i_wr.b_en) begin
            r_bias <= i_wr.data;
        end
    end

    // One weight times one feature per cycle
    assign w_prod = r_w[i_sel] * i_feat;

    // Start from the scaled bias, then accumulate with wraparound
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.preload) begin
            n_acc = bias_scale(r_bias, i_q_shift);
        end else if (i_ctl.mac) begin
            n_acc = r_acc + w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctl.fin) begin
            r_hidden <= hidden_clamp(shift_down(r_acc, i_q_shift));
        end
    end

    assign o_hidden = r_hidden;

endmodule

/* rtl/qmlp_merge.sv */
module qmlp_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qmlp_pkg::t_merge_wr   i_wr,
    input  logic                  i_start,
    input  qmlp_pkg::t_hidden_vec i_hidden,
    input  qmlp_pkg::t_shift      i_q_shift,
    input  qmlp_pkg::t_acc        i_ratio_min,
    input  qmlp_pkg::t_acc        i_ratio_max,
    input  logic                  i_out_ready,
    output qmlp_pkg::t_merge_stat o_stat,
    output logic                  o_out_valid,
    output qmlp_pkg::t_acc        o_ratio
);
    import qmlp_pkg::*;

    t_word                r_ow [HIDDEN_COUNT];
    t_word                r_obias;
    t_hidden_vec          r_hid;
    t_acc                 r_acc;
    logic [MSTEP_W-1:0]   r_step;
    logic                 r_busy;
    logic                 r_out_valid;
    t_acc                 r_ratio;
    t_hid_sel             w_sel;
    t_acc                 w_prod;
    t_acc                 w_scaled;
    t_acc                 w_clamped;
    logic                 w_mac;
    logic                 w_finish;

    // Hold the output weights and output bias
    always_ff @(posedge i_clk) begin
        if (i_wr.ow_en) begin
            r_ow[i_wr.ow_sel] <= i_wr.data;
        end
        if (i_wr.ob_en) begin
            r_obias <= i_wr.data;
        end
    end

    assign w_sel  = r_step[HID_IDX_W-1:0];
    assign w_prod = r_ow[w_sel] * t_word'({1'b0, r_hid[w_sel]});

    assign w_mac    = r_busy && (r_step < MSTEP_W'(HIDDEN_COUNT));
    assign w_finish = r_busy && (r_step == MSTEP_W'(HIDDEN_COUNT))
                      && (!r_out_valid || i_out_ready);

    // Scale down, then clamp with the lower bound tested first
    assign w_scaled = shift_down(r_acc, i_q_shift);
    always_comb begin
        if (w_scaled < i_ratio_min) begin
            w_clamped = i_ratio_min;
        end else if (w_scaled > i_ratio_max) begin
            w_clamped = i_ratio_max;
        end else begin
            w_clamped = w_scaled;
        end
    end

    // Capture hidden values and accumulate one product per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hid <= i_hidden;
            r_acc <= bias_scale(r_obias, i_q_shift);
        end else if (w_mac) begin
            r_acc <= r_acc + w_prod;
        end
        if (w_finish) begin
            r_ratio <= w_clamped;
        end
    end

    // Sequence the merge and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (w_mac) begin
                r_step <= r_step + 1'b1;
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.can_start = !r_busy || w_finish;
    assign o_out_valid      = r_out_valid;
    assign o_ratio          = r_ratio;

endmodule

/* rtl/quantized_mlp_4x8_infer.sv */
// From the accepting edge to a valid result with the merge stage free, the steps are:
// bias preload on that edge, 4 lane MACs, clamp, handoff, 8 merge MACs, output clamp.
// A new inference can enter the lanes while the last is still in the merge stage, whose
// single multiplier limits throughput. A load beat waits for idle lanes and merge.
// Synchronous active-low reset clears the sequencers and output valid, and sets
// q_shift = 8, ratio_min = 0, ratio_max = 2147483647; weights are not cleared.
`include "quantized_mlp_4x8_infer_macros.svh"

module quantized_mlp_4x8_infer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  qmlp_pkg::t_index    i_weight_index,
    input  qmlp_pkg::t_word     i_weight_value,
    input  qmlp_pkg::t_word     i_feature_0,
    input  qmlp_pkg::t_word     i_feature_1,
    input  qmlp_pkg::t_word     i_feature_2,
    input  qmlp_pkg::t_word     i_feature_3,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output qmlp_pkg::t_acc      o_ratio,
    // Configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  qmlp_pkg::t_cfg_idx  i_cfg_index,
    input  qmlp_pkg::t_cfg_data i_cfg_data
);
    import qmlp_pkg::*;

    localparam t_index HID_B_BASE_I  = INDEX_W'(HID_B_BASE);
    localparam t_index OUT_W_BASE_I  = INDEX_W'(OUT_W_BASE);
    localparam t_index OUT_B_INDEX_I = INDEX_W'(OUT_B_INDEX);

    // Configuration registers
    t_shift r_q_shift;
    t_acc   r_ratio_min;
    t_acc   r_ratio_max;

    // Lane sequencer
    logic               r_lane_busy;
    logic               r_lane_hold;
    logic [LSTEP_W-1:0] r_lane_step;
    t_word              r_feat [INPUT_COUNT];

    t_lane_ctl   w_ctl;
    t_lane_wr    w_lane_wr [HIDDEN_COUNT];
    t_merge_wr   w_merge_wr;
    t_merge_stat w_merge_stat;
    t_hidden_vec w_hidden;
    t_in_sel     w_sel;
    logic        w_handoff;
    logic        w_infer_ready;
    logic        w_load_ready;
    logic        w_in_fire;
    logic        w_infer_go;
    logic        w_load_go;
    logic        w_in_hw;
    logic        w_in_hb;
    logic        w_in_ow;
    t_hid_sel    w_hw_lane;
    t_hid_sel    w_hb_lane;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_shift   <= Q_SHIFT_RESET;
            r_ratio_min <= RATIO_MIN_RESET;
            r_ratio_max <= RATIO_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_Q_SHIFT:   r_q_shift   <= i_cfg_data[SHIFT_W-1:0];
                CFG_RATIO_MIN: r_ratio_min <= t_acc'(i_cfg_data);
                CFG_RATIO_MAX: r_ratio_max <= t_acc'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Handshake: inferences overlap the merge, loads wait for an empty pipe
    assign w_handoff     = r_lane_hold && w_merge_stat.can_start;
    assign w_infer_ready = !r_lane_busy || w_handoff;
    assign w_load_ready  = !r_lane_busy && !w_merge_stat.busy;
    assign o_in_ready    = (i_operation == OP_INFER) ? w_infer_ready : w_load_ready;
    assign w_in_fire     = i_in_valid && o_in_ready;
    assign w_infer_go    = w_in_fire && (i_operation == OP_INFER);
    assign w_load_go     = w_in_fire && (i_operation == OP_LOAD);

    // Lane controls
    assign w_ctl.preload = w_infer_go;
    assign w_ctl.mac     = r_lane_busy && !r_lane_hold
                           && (r_lane_step < LSTEP_W'(INPUT_COUNT));
    assign w_ctl.fin     = r_lane_busy && !r_lane_hold
                           && (r_lane_step == LSTEP_W'(INPUT_COUNT));
    assign w_sel         = r_lane_step[IN_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_busy <= 1'b0;
            r_lane_hold <= 1'b0;
            r_lane_step <= '0;
        end else if (w_infer_go) begin
            r_lane_busy <= 1'b1;
            r_lane_hold <= 1'b0;
            r_lane_step <= '0;
        end else if (w_handoff) begin
            r_lane_busy <= 1'b0;
            r_lane_hold <= 1'b0;
        end else if (w_ctl.fin) begin
            r_lane_hold <= 1'b1;
        end else if (w_ctl.mac) begin
            r_lane_step <= r_lane_step + 1'b1;
        end
    end

    // Latch the features of an accepted inference
    always_ff @(posedge i_clk) begin
        if (w_infer_go) begin
            r_feat[0] <= i_feature_0;
            r_feat[1] <= i_feature_1;
            r_feat[2] <= i_feature_2;
            r_feat[3] <= i_feature_3;
        end
    end

    // Decode the weight word index of a load
    assign w_in_hw   = (i_weight_index < HID_B_BASE_I);
    assign w_in_hb   = (i_weight_index >= HID_B_BASE_I) && (i_weight_index < OUT_W_BASE_I);
    assign w_in_ow   = (i_weight_index >= OUT_W_BASE_I) && (i_weight_index < OUT_B_INDEX_I);
    assign w_hw_lane = HID_IDX_W'(i_weight_index >> IN_IDX_W);
    assign w_hb_lane = HID_IDX_W'(i_weight_index - HID_B_BASE_I);

    assign w_merge_wr.ow_en  = w_load_go && w_in_ow;
    assign w_merge_wr.ow_sel = HID_IDX_W'(i_weight_index - OUT_W_BASE_I);
    assign w_merge_wr.ob_en  = w_load_go && (i_weight_index == OUT_B_INDEX_I);
    assign w_merge_wr.data   = i_weight_value;

    // Hidden unit lanes
    for (genvar g = 0; g < HIDDEN_COUNT; g++) begin : g_lane
        assign w_lane_wr[g].w_en  = w_load_go && w_in_hw && (w_hw_lane == HID_IDX_W'(g));
        assign w_lane_wr[g].w_sel = i_weight_index[IN_IDX_W-1:0];
        assign w_lane_wr[g].b_en  = w_load_go && w_in_hb && (w_hb_lane == HID_IDX_W'(g));
        assign w_lane_wr[g].data  = i_weight_value;

        qmlp_lane u_lane (
            .i_clk     (i_clk),
            .i_wr      (w_lane_wr[g]),
            .i_ctl     (w_ctl),
            .i_sel     (w_sel),
            .i_feat    (r_feat[w_sel]),
            .i_q_shift (r_q_shift),
            .o_hidden  (w_hidden[g])
        );
    end

    // Output layer merge
    qmlp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_merge_wr),
        .i_start     (w_handoff),
        .i_hidden    (w_hidden),
        .i_q_shift   (r_q_shift),
        .i_ratio_min (r_ratio_min),
        .i_ratio_max (r_ratio_max),
        .i_out_ready (i_out_ready),
        .o_stat      (w_merge_stat),
        .o_out_valid (o_out_valid),
        .o_ratio     (o_ratio)
    );

    // Checks
    `QMLP_ASSERT_NEXT(a_infer_starts, w_infer_go, r_lane_busy && !r_lane_hold && (r_lane_step == '0), "inference did not restart the lanes")
    `QMLP_ASSERT_NEXT(a_fin_holds, w_ctl.fin && !w_infer_go, r_lane_hold && r_lane_busy, "lanes did not hold finished hidden values")
    `QMLP_ASSERT_NOW(a_hold_step, r_lane_hold, r_lane_step == LSTEP_W'(INPUT_COUNT), "lane hold at wrong step")
    `QMLP_ASSERT_NOW(a_load_idle, w_load_go, !r_lane_busy && !w_merge_stat.busy, "weight load while inference in flight")

endmodule
